// ===== hw/rtl/hidf_pkg.sv =====
package hidf_pkg;

	// descriptor codes
	localparam logic [7:0] DESC_TYPE_INTERFACE = 8'd4;
	localparam logic [7:0] DESC_TYPE_ENDPOINT  = 8'd5;
	localparam logic [7:0] IFACE_CLASS_HID     = 8'd3;
	localparam logic [1:0] XFER_TYPE_INTERRUPT = 2'd3;

	// byte positions inside a descriptor
	localparam logic [7:0] OFF_LENGTH       = 8'd0;
	localparam logic [7:0] OFF_TYPE         = 8'd1;
	localparam logic [7:0] OFF_EP_ADDRESS   = 8'd2;
	localparam logic [7:0] OFF_EP_ATTR      = 8'd3;
	localparam logic [7:0] OFF_EP_MPS_LO    = 8'd4;
	localparam logic [7:0] OFF_EP_MPS_HI    = 8'd5;
	localparam logic [7:0] OFF_IF_CLASS     = 8'd5;
	localparam logic [7:0] OFF_EP_INTERVAL  = 8'd6;
	localparam logic [7:0] MIN_DESC_LENGTH  = 8'd2;

	// reported when nothing matched, or when the match is endpoint 0
	localparam logic [10:0] DEFAULT_MPS      = 11'd8;
	localparam logic [7:0]  DEFAULT_INTERVAL = 8'd8;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} desc_word_t;

	typedef struct packed {
		logic        found;
		logic [3:0]  endpoint_number;
		logic [10:0] max_packet_size;
		logic [7:0]  poll_interval;
	} res_word_t;

endpackage

// ===== hw/rtl/hid_interrupt_endpoint_finder_unit.sv =====
// Scans a USB configuration descriptor set, one byte per word, and on the word
// marked last_byte returns one result word: the first interrupt IN endpoint
// found under a HID interface (number, max packet size masked to 11 bits,
// interval), or found = 0 with packet size 8 and interval 8 if none is found
// or the first match is endpoint 0. The block takes one byte per clock while
// desc_stall is low, and registers the result into the result buffer. The
// walk stops on a length byte below 2, at a matching endpoint, or after
// MAX_TOTAL bytes; later bytes of that stream are accepted and ignored. A
// two-deep result buffer lets the next stream flow while a result waits;
// desc_stall rises only when both result slots are full.
module hid_interrupt_endpoint_finder_unit #(
	parameter int MAX_TOTAL = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 desc_valid,
	output logic                 desc_stall,
	input  hidf_pkg::desc_word_t desc_word,
	output logic                 res_valid,
	input  logic                 res_stall,
	output hidf_pkg::res_word_t  res_word
);

	localparam int SEEN_W = $clog2(MAX_TOTAL + 1);

	// walk state
	logic [SEEN_W-1:0] seen_q, seen_n;
	logic [7:0]        off_q, off_n;
	logic [7:0]        len_q, len_n;
	logic [7:0]        type_q, type_n;
	logic              hid_q, hid_n;
	logic              stop_q, stop_n;

	// candidate endpoint bytes, kept only as wide as the result needs
	logic              ep_in_q, ep_in_n;
	logic [3:0]        ep_num_q, ep_num_n;
	logic [1:0]        ep_attr_q, ep_attr_n;
	logic [10:0]       ep_mps_q, ep_mps_n;

	hidf_pkg::res_word_t found_q, found_n;

	// output buffer: head register and skid slot
	logic                res_valid_q, skid_valid_q;
	hidf_pkg::res_word_t res_q, skid_q;

	logic accept, take, push, pop, matched;
	logic [8:0] off_inc;
	hidf_pkg::res_word_t default_res;

	assign desc_stall = skid_valid_q;
	assign accept     = desc_valid && !desc_stall;
	assign take       = accept && !stop_q && (seen_q < SEEN_W'(MAX_TOTAL));
	assign push       = accept && desc_word.last_byte;
	assign pop        = res_valid_q && !res_stall;
	assign off_inc    = {1'b0, off_q} + 9'd1;

	assign default_res = '{found: 1'b0, endpoint_number: 4'd0,
		max_packet_size: hidf_pkg::DEFAULT_MPS, poll_interval: hidf_pkg::DEFAULT_INTERVAL};

	// per-byte walk over the descriptors
	always_comb begin
		seen_n    = seen_q;
		off_n     = off_q;
		len_n     = len_q;
		type_n    = type_q;
		hid_n     = hid_q;
		stop_n    = stop_q;
		ep_in_n   = ep_in_q;
		ep_num_n  = ep_num_q;
		ep_attr_n = ep_attr_q;
		ep_mps_n  = ep_mps_q;
		found_n   = found_q;
		matched   = 1'b0;
		if (take) begin
			seen_n = seen_q + SEEN_W'(1);
			case (off_q)
				hidf_pkg::OFF_LENGTH: begin
					if (desc_word.data_byte < hidf_pkg::MIN_DESC_LENGTH) begin
						stop_n = 1'b1;
					end else begin
						len_n  = desc_word.data_byte;
						type_n = 8'd0;
						off_n  = 8'd1;
					end
				end
				hidf_pkg::OFF_TYPE: begin
					type_n = desc_word.data_byte;
					if (desc_word.data_byte == hidf_pkg::DESC_TYPE_INTERFACE) begin
						hid_n = 1'b0;
					end
					off_n = (off_inc >= {1'b0, len_q}) ? 8'd0 : off_inc[7:0];
				end
				default: begin
					if (type_q == hidf_pkg::DESC_TYPE_INTERFACE && off_q == hidf_pkg::OFF_IF_CLASS) begin
						hid_n = (desc_word.data_byte == hidf_pkg::IFACE_CLASS_HID);
					end
					if (type_q == hidf_pkg::DESC_TYPE_ENDPOINT && hid_q) begin
						if (off_q == hidf_pkg::OFF_EP_ADDRESS) begin
							ep_in_n  = desc_word.data_byte[7];
							ep_num_n = desc_word.data_byte[3:0];
						end else if (off_q == hidf_pkg::OFF_EP_ATTR) begin
							ep_attr_n = desc_word.data_byte[1:0];
						end else if (off_q == hidf_pkg::OFF_EP_MPS_LO) begin
							ep_mps_n[7:0] = desc_word.data_byte;
						end else if (off_q == hidf_pkg::OFF_EP_MPS_HI) begin
							ep_mps_n[10:8] = desc_word.data_byte[2:0];
						end else if (off_q == hidf_pkg::OFF_EP_INTERVAL) begin
							if (ep_in_q && ep_attr_q == hidf_pkg::XFER_TYPE_INTERRUPT) begin
								matched = 1'b1;
								stop_n  = 1'b1;
								if (ep_num_q != 4'd0) begin
									found_n = '{found: 1'b1, endpoint_number: ep_num_q,
										max_packet_size: ep_mps_q,
										poll_interval: desc_word.data_byte};
								end
							end
						end
					end
					if (!matched) begin
						off_n = (off_inc >= {1'b0, len_q}) ? 8'd0 : off_inc[7:0];
					end
				end
			endcase
		end
	end

	// walk registers; the last byte returns everything to the start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= '0;
			off_q   <= '0;
			len_q   <= '0;
			type_q  <= '0;
			hid_q   <= 1'b0;
			stop_q  <= 1'b0;
			found_q <= default_res;
		end else if (push) begin
			seen_q  <= '0;
			off_q   <= '0;
			len_q   <= '0;
			type_q  <= '0;
			hid_q   <= 1'b0;
			stop_q  <= 1'b0;
			found_q <= default_res;
		end else if (accept) begin
			seen_q  <= seen_n;
			off_q   <= off_n;
			len_q   <= len_n;
			type_q  <= type_n;
			hid_q   <= hid_n;
			stop_q  <= stop_n;
			found_q <= found_n;
		end
	end

	// candidate bytes are only read after being written in the same descriptor
	always_ff @(posedge clk) begin
		if (accept) begin
			ep_in_q   <= ep_in_n;
			ep_num_q  <= ep_num_n;
			ep_attr_q <= ep_attr_n;
			ep_mps_q  <= ep_mps_n;
		end
	end

	// result buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				res_valid_q <= push;
			end
		end else if (push) begin
			if (res_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				res_valid_q <= 1'b1;
			end
		end
	end

	// result buffer data
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				res_q <= skid_q;
			end else if (push) begin
				res_q <= found_n;
			end
		end else if (push) begin
			if (res_valid_q) begin
				skid_q <= found_n;
			end else begin
				res_q <= found_n;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_q;

	// skid slot only fills behind a waiting head word
	a_skid_behind_head: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> res_valid_q)
		else $error("skid word held without head word");

	// byte count never passes the stream limit
	a_seen_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= SEEN_W'(MAX_TOTAL))
		else $error("byte count beyond limit");

	// a last byte always leaves a result word waiting
	a_last_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> res_valid_q)
		else $error("last byte produced no result word");

	// a stream always restarts from the first descriptor byte
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (off_q == 8'd0 && !stop_q && seen_q == '0))
		else $error("walk state not cleared after last byte");

endmodule
